@@ hdl/lbp_3x3_stream_assert.svh @@
// lbp_3x3_stream_assert.svh: assertion macros shared by the LBP stream RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
// With SYNTH defined the macros expand to nothing.
`ifndef LBP_3X3_STREAM_ASSERT_SVH
`define LBP_3X3_STREAM_ASSERT_SVH
`ifndef SYNTH
// Clocked property check with a reset that disables it.
`define LBP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lbp_3x3_stream: assertion failed");
// Condition that must never be true at a clock edge.
`define LBP_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("lbp_3x3_stream: forbidden condition seen");
`else
`define LBP_ASSERT(lbl, clk, rst, prop)
`define LBP_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ hdl/lbp_pkg.sv @@
// lbp_pkg: widths, register indexes, shared types and the intensity function
// for the 3x3 local binary pattern stream. No dependencies.
package lbp_pkg;

   localparam int LBP_PIX_W     = 8;
   localparam int LBP_MAX_WIDTH = 1024;
   localparam int LBP_COL_W     = $clog2(LBP_MAX_WIDTH);
   localparam int LBP_WID_W     = 11;
   localparam int LBP_HGT_W     = 13;
   localparam int LBP_IN_ROW_W  = LBP_HGT_W + 1;
   localparam int LBP_SUM_W     = LBP_PIX_W + 2;

   localparam int LBP_CSR_IDX_W  = 2;
   localparam int LBP_CSR_DATA_W = 13;

   localparam logic [LBP_CSR_IDX_W-1:0] LBP_CSR_WIDTH  = 2'd0;
   localparam logic [LBP_CSR_IDX_W-1:0] LBP_CSR_HEIGHT = 2'd1;
   localparam logic [LBP_CSR_IDX_W-1:0] LBP_CSR_COLOR  = 2'd2;

   localparam logic [LBP_WID_W-1:0] LBP_WIDTH_RESET  = 11'd640;
   localparam logic [LBP_HGT_W-1:0] LBP_HEIGHT_RESET = 13'd480;
   localparam logic [LBP_WID_W-1:0] LBP_WIDTH_LIMIT  = 11'd1024;

   localparam logic [LBP_CSR_DATA_W-1:0] LBP_DIV3_RECIP = 13'd683;
   localparam int LBP_DIV3_SHIFT = 11;

   // One new window column plus what the code stage must do with it.
   typedef struct packed {
      logic                 emit;
      logic                 last;
      logic [LBP_PIX_W-1:0] top;
      logic [LBP_PIX_W-1:0] mid;
      logic [LBP_PIX_W-1:0] val;
   } lbp_col_type;

   // Gray sample, or floor((r+g+b)/3) via multiply by 683 and shift by 11,
   // which is exact for every sum up to 765.
   function automatic logic [LBP_PIX_W-1:0] lbp_intensity(
      input logic [LBP_PIX_W-1:0] red,
      input logic [LBP_PIX_W-1:0] green,
      input logic [LBP_PIX_W-1:0] blue,
      input logic                 color);
      logic [LBP_SUM_W-1:0]             sum;
      logic [LBP_SUM_W+LBP_CSR_DATA_W-1:0] prod;
      sum  = LBP_SUM_W'(red) + LBP_SUM_W'(green) + LBP_SUM_W'(blue);
      prod = (LBP_SUM_W + LBP_CSR_DATA_W)'(sum) * (LBP_SUM_W + LBP_CSR_DATA_W)'(LBP_DIV3_RECIP);
      if (color) begin
         return prod[LBP_DIV3_SHIFT +: LBP_PIX_W];
      end else begin
         return red;
      end
   endfunction

endpackage

@@ hdl/lbp_line_buf.sv @@
// lbp_line_buf: the two row memories (upper and middle line) with registered
// reads and a bypass for a write to the address read in the same cycle. Uses lbp_pkg.
`include "lbp_3x3_stream_assert.svh"
module lbp_line_buf (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [lbp_pkg::LBP_COL_W-1:0]  rd_addr,
   input  logic                           wr_en,
   input  logic [lbp_pkg::LBP_COL_W-1:0]  wr_addr,
   input  logic [lbp_pkg::LBP_PIX_W-1:0]  wr_val,
   output logic [lbp_pkg::LBP_PIX_W-1:0]  top,
   output logic [lbp_pkg::LBP_PIX_W-1:0]  mid
);
   import lbp_pkg::*;

   logic [LBP_PIX_W-1:0] upper_mem  [LBP_MAX_WIDTH];
   logic [LBP_PIX_W-1:0] middle_mem [LBP_MAX_WIDTH];

   logic [LBP_PIX_W-1:0] upper_rd_ff;
   logic [LBP_PIX_W-1:0] middle_rd_ff;
   logic [LBP_PIX_W-1:0] byp_top_ff;
   logic [LBP_PIX_W-1:0] byp_mid_ff;
   logic                 byp_ff;
   logic                 byp_in;

   // The middle value read for an item moves up into the upper line.
   assign top    = byp_ff ? byp_top_ff : upper_rd_ff;
   assign mid    = byp_ff ? byp_mid_ff : middle_rd_ff;
   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr]  <= mid;
         middle_mem[wr_addr] <= wr_val;
      end
      if (rd_en) begin
         upper_rd_ff  <= upper_mem[rd_addr];
         middle_rd_ff <= middle_mem[rd_addr];
         byp_top_ff   <= mid;
         byp_mid_ff   <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= byp_in;
      end
   end

endmodule

@@ hdl/lbp_code_stage.sv @@
// lbp_code_stage: 3x3 window, output position counters, border masks, the
// neighbor compare and the result register. Uses lbp_pkg and the assertion macros.
`include "lbp_3x3_stream_assert.svh"
module lbp_code_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           restart,
   input  logic                           load,
   input  lbp_pkg::lbp_col_type           col,
   input  logic [lbp_pkg::LBP_WID_W-1:0]  eff_w,
   input  logic [lbp_pkg::LBP_HGT_W-1:0]  eff_h,
   output logic                           slot_free,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [lbp_pkg::LBP_PIX_W-1:0]  rsp_lbp_code,
   output logic                           rsp_frame_last
);
   import lbp_pkg::*;

   // Columns 0 and 1 of the window; column 2 is the incoming column.
   logic [LBP_PIX_W-1:0] win_ff [3][2];
   logic [LBP_COL_W-1:0] out_col_ff;
   logic [LBP_HGT_W-1:0] out_row_ff;
   logic                 rsp_valid_ff;
   logic [LBP_PIX_W-1:0] code_ff;
   logic                 last_ff;

   logic [LBP_PIX_W-1:0] center;
   logic                 up_ok, dn_ok, lf_ok, rt_ok;
   logic                 col_wrap;
   logic [LBP_PIX_W-1:0] code_in;

   assign center   = win_ff[1][1];
   assign up_ok    = (out_row_ff != '0);
   assign dn_ok    = ({1'b0, out_row_ff} + LBP_IN_ROW_W'(1)) < {1'b0, eff_h};
   assign lf_ok    = (out_col_ff != '0);
   assign rt_ok    = ({1'b0, out_col_ff} + LBP_WID_W'(1)) < eff_w;
   assign col_wrap = !rt_ok;

   // Weights 1,2,4 above, 8,16 beside, 32,64,128 below, as bits 0 to 7.
   always_comb begin
      code_in[0] = up_ok && lf_ok && (win_ff[0][0] >= center);
      code_in[1] = up_ok && (win_ff[0][1] >= center);
      code_in[2] = up_ok && rt_ok && (col.top >= center);
      code_in[3] = lf_ok && (win_ff[1][0] >= center);
      code_in[4] = rt_ok && (col.mid >= center);
      code_in[5] = dn_ok && lf_ok && (win_ff[2][0] >= center);
      code_in[6] = dn_ok && (win_ff[2][1] >= center);
      code_in[7] = dn_ok && rt_ok && (col.val >= center);
   end

   assign slot_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lbp_code   = code_ff;
   assign rsp_frame_last = last_ff;

   always_ff @(posedge clock) begin
      if (reset || restart || (load && col.last)) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= '0;
            win_ff[r][1] <= '0;
         end
      end else if (load) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
         end
         win_ff[0][1] <= col.top;
         win_ff[1][1] <= col.mid;
         win_ff[2][1] <= col.val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else if (load && col.emit) begin
         if (col.last) begin
            out_col_ff <= '0;
            out_row_ff <= '0;
         end else if (col_wrap) begin
            out_col_ff <= '0;
            out_row_ff <= out_row_ff + LBP_HGT_W'(1);
         end else begin
            out_col_ff <= out_col_ff + LBP_COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load && col.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && col.emit) begin
         code_ff <= code_in;
         last_ff <= col.last;
      end
   end

   `LBP_ASSERT(a_out_row_bound, clock, reset, out_row_ff < eff_h)
   `LBP_ASSERT(a_last_rewinds_out, clock, reset,
      rsp_valid_ff && last_ff |-> (out_row_ff == '0) && (out_col_ff == '0))
   `LBP_NEVER(a_rsp_no_overwrite, clock, reset,
      load && col.emit && rsp_valid_ff && !rsp_ready)

endmodule

@@ hdl/lbp_3x3_stream.sv @@
// lbp_3x3_stream: top level of the 3x3 local binary pattern stream.
// Depends on lbp_pkg, lbp_line_buf, lbp_code_stage and the assertion macros.
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    req_cmd, req_red, req_green, req_blue
// rsp      out        rsp_valid/rsp_ready    rsp_lbp_code, rsp_frame_last
// csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// One item is taken per clock while req_ready is high. An item passes two register
// stages: the input stage, where the line memories are read, and the result
// register, written from the window compare. A code therefore leaves one row plus
// one item after its pixel. Reset is synchronous; no memory sweep follows it.
// When rsp_ready is low the result register holds, the input stage holds behind
// it, and req_ready drops only when both are full.
`include "lbp_3x3_stream_assert.svh"
module lbp_3x3_stream (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [lbp_pkg::LBP_PIX_W-1:0]       req_red,
   input  logic [lbp_pkg::LBP_PIX_W-1:0]       req_green,
   input  logic [lbp_pkg::LBP_PIX_W-1:0]       req_blue,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [lbp_pkg::LBP_PIX_W-1:0]       rsp_lbp_code,
   output logic                                rsp_frame_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lbp_pkg::LBP_CSR_IDX_W-1:0]   csr_index,
   input  logic [lbp_pkg::LBP_CSR_DATA_W-1:0]  csr_data
);
   import lbp_pkg::*;

   // Configuration registers and their effective values.
   logic [LBP_WID_W-1:0] image_width_ff;
   logic [LBP_HGT_W-1:0] image_height_ff;
   logic                 color_mode_ff;
   logic [LBP_WID_W-1:0] eff_w;
   logic [LBP_HGT_W-1:0] eff_h;
   logic                 csr_write;
   logic                 restart;

   // Input position of the next item taken.
   logic [LBP_COL_W-1:0]    in_col_ff;
   logic [LBP_IN_ROW_W-1:0] in_row_ff;

   // Input stage: one item whose line memory read is in flight.
   logic                 a_valid_ff;
   logic [LBP_COL_W-1:0] a_col_ff;
   logic [LBP_PIX_W-1:0] a_val_ff;
   logic                 a_emit_ff;
   logic                 a_last_ff;
   logic                 a_adv;

   logic                    accept;
   logic                    in_frame;
   logic                    enter;
   logic                    in_last;
   logic                    in_emit;
   logic                    in_wrap;
   logic [LBP_PIX_W-1:0]    val_in;
   logic [LBP_IN_ROW_W-1:0] h_ext;

   logic [LBP_PIX_W-1:0] lb_top;
   logic [LBP_PIX_W-1:0] lb_mid;
   lbp_col_type          col;
   logic                 slot_free;

   // A width of zero acts as one and a width beyond the line memory is clipped;
   // a height of zero acts as one.
   always_comb begin
      if (image_width_ff == '0) begin
         eff_w = LBP_WID_W'(1);
      end else if (image_width_ff > LBP_WIDTH_LIMIT) begin
         eff_w = LBP_WIDTH_LIMIT;
      end else begin
         eff_w = image_width_ff;
      end
      eff_h = (image_height_ff == '0) ? LBP_HGT_W'(1) : image_height_ff;
   end

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Only a write to a defined register restarts the frame.
   always_comb begin
      case (csr_index)
         LBP_CSR_WIDTH:  restart = csr_write;
         LBP_CSR_HEIGHT: restart = csr_write;
         LBP_CSR_COLOR:  restart = csr_write;
         default:        restart = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= LBP_WIDTH_RESET;
         image_height_ff <= LBP_HEIGHT_RESET;
         color_mode_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            LBP_CSR_WIDTH:  image_width_ff  <= csr_data[LBP_WID_W-1:0];
            LBP_CSR_HEIGHT: image_height_ff <= csr_data[LBP_HGT_W-1:0];
            LBP_CSR_COLOR:  color_mode_ff   <= csr_data[0];
            default:        ;
         endcase
      end
   end

   // Front end. Inside the frame a flush item does nothing at all. Once the
   // frame's pixels are in, every item drains one position with a zero sample.
   // The item that emits the frame's final code is known here from the input
   // position, so the input counters rewind as it is taken.
   assign h_ext    = {1'b0, eff_h};
   assign accept   = req_valid && req_ready;
   assign in_frame = in_row_ff < h_ext;
   assign enter    = !(in_frame && req_cmd);
   assign in_last  = (in_row_ff == (h_ext + LBP_IN_ROW_W'(1))) && (in_col_ff == '0);
   assign in_emit  = (in_row_ff > LBP_IN_ROW_W'(1)) ||
                     ((in_row_ff == LBP_IN_ROW_W'(1)) && (in_col_ff != '0));
   assign in_wrap  = ({1'b0, in_col_ff} + LBP_WID_W'(1)) >= eff_w;
   assign val_in   = in_frame ?
                     lbp_intensity(req_red, req_green, req_blue, color_mode_ff) : '0;

   assign a_adv     = a_valid_ff && slot_free;
   assign req_ready = !a_valid_ff || a_adv;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         in_col_ff <= '0;
         in_row_ff <= '0;
      end else if (accept && enter) begin
         if (in_last) begin
            in_col_ff <= '0;
            in_row_ff <= '0;
         end else if (in_wrap) begin
            in_col_ff <= '0;
            in_row_ff <= in_row_ff + LBP_IN_ROW_W'(1);
         end else begin
            in_col_ff <= in_col_ff + LBP_COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (accept && enter) begin
         a_valid_ff <= 1'b1;
      end else if (a_adv) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && enter) begin
         a_col_ff  <= in_col_ff;
         a_val_ff  <= val_in;
         a_emit_ff <= in_emit;
         a_last_ff <= in_last;
      end
   end

   lbp_line_buf u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && enter),
      .rd_addr (in_col_ff),
      .wr_en   (a_adv),
      .wr_addr (a_col_ff),
      .wr_val  (a_val_ff),
      .top     (lb_top),
      .mid     (lb_mid)
   );

   always_comb begin
      col.emit = a_emit_ff;
      col.last = a_last_ff;
      col.top  = lb_top;
      col.mid  = lb_mid;
      col.val  = a_val_ff;
   end

   lbp_code_stage u_code_stage (
      .clock          (clock),
      .reset          (reset),
      .restart        (restart),
      .load           (a_adv),
      .col            (col),
      .eff_w          (eff_w),
      .eff_h          (eff_h),
      .slot_free      (slot_free),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_lbp_code   (rsp_lbp_code),
      .rsp_frame_last (rsp_frame_last)
   );

   `LBP_ASSERT(a_in_row_bound, clock, reset, in_row_ff <= (h_ext + LBP_IN_ROW_W'(1)))
   `LBP_ASSERT(a_in_col_bound, clock, reset, ({1'b0, in_col_ff} < eff_w))
   `LBP_ASSERT(a_stage_holds, clock, reset,
      a_valid_ff && !a_adv |=> a_valid_ff && $stable(a_col_ff) && $stable(a_val_ff))
   `LBP_ASSERT(a_last_rewinds_in, clock, reset,
      a_valid_ff && a_last_ff |-> (in_row_ff == '0) && (in_col_ff == '0))

endmodule

@@ verif/lbp_tb_pkg.sv @@
// lbp_tb_pkg: item command codes and the spare register index shared by the
// LBP stream checker and the testbench top. Depends on lbp_pkg.
package lbp_tb_pkg;

   typedef enum logic {
      LBP_CMD_PIXEL = 1'b0,
      LBP_CMD_FLUSH = 1'b1
   } lbp_cmd_type;

   // Index with no register behind it; a write there changes nothing.
   localparam logic [lbp_pkg::LBP_CSR_IDX_W-1:0] LBP_CSR_SPARE = 2'd3;

endpackage

@@ verif/lbp_checker.sv @@
// lbp_checker: watches the req, rsp and csr channels of lbp_3x3_stream, predicts
// each pattern code from the accepted items and compares it with the block's output.
// Depends on lbp_pkg and lbp_tb_pkg.
module lbp_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_cmd,
   input  logic [lbp_pkg::LBP_PIX_W-1:0]      req_red,
   input  logic [lbp_pkg::LBP_PIX_W-1:0]      req_green,
   input  logic [lbp_pkg::LBP_PIX_W-1:0]      req_blue,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [lbp_pkg::LBP_PIX_W-1:0]      rsp_lbp_code,
   input  logic                               rsp_frame_last,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [lbp_pkg::LBP_CSR_IDX_W-1:0]  csr_index,
   input  logic [lbp_pkg::LBP_CSR_DATA_W-1:0] csr_data,
   output int                                 errors,
   output int                                 pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import lbp_pkg::*;
   import lbp_tb_pkg::*;

   localparam logic [LBP_PIX_W-1:0] NEIGHBOR_WEIGHT [3][3] = '{
      '{8'd1,  8'd2,  8'd4},
      '{8'd8,  8'd0,  8'd16},
      '{8'd32, 8'd64, 8'd128}
   };

   typedef struct packed {
      logic [LBP_PIX_W-1:0] code;
      logic                 last;
   } lbp_result_type;

   lbp_result_type expected_codes [$];

   logic [LBP_WID_W-1:0] cfg_width;
   logic [LBP_HGT_W-1:0] cfg_height;
   logic                 cfg_color;

   logic [LBP_PIX_W-1:0] upper_row_mem  [LBP_MAX_WIDTH];
   logic [LBP_PIX_W-1:0] middle_row_mem [LBP_MAX_WIDTH];
   logic [LBP_PIX_W-1:0] win [3][3];
   int in_col, in_row, out_col, out_row;
   int mismatch_count = 0;

   function automatic int frame_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > LBP_MAX_WIDTH) return LBP_MAX_WIDTH;
      return int'(cfg_width);
   endfunction

   function automatic int frame_height();
      return (cfg_height == 0) ? 1 : int'(cfg_height);
   endfunction

   function automatic void restart_frame();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            win[r][c] = '0;
   endfunction

   function automatic void apply_register(input logic [LBP_CSR_IDX_W-1:0] idx,
                                          input logic [LBP_CSR_DATA_W-1:0] data);
      case (idx)
         LBP_CSR_WIDTH: begin
            cfg_width = data[LBP_WID_W-1:0];
            restart_frame();
         end
         LBP_CSR_HEIGHT: begin
            cfg_height = data[LBP_HGT_W-1:0];
            restart_frame();
         end
         LBP_CSR_COLOR: begin
            cfg_color = data[0];
            restart_frame();
         end
         default: ;
      endcase
   endfunction

   // Shifts any item but an in-frame flush into the line memories and the window, and
   // queues the code of the pixel one row plus one position behind it when there is one.
   function automatic void shift_in_pixel(input logic cmd,
                                          input logic [LBP_PIX_W-1:0] r_in,
                                          input logic [LBP_PIX_W-1:0] g_in,
                                          input logic [LBP_PIX_W-1:0] b_in);
      int w, h, col, nr, nc;
      logic [LBP_PIX_W-1:0] sample, above, beside, center, code;
      logic emit, last;
      lbp_result_type item;
      w = frame_width();
      h = frame_height();
      sample = '0;
      if (in_row < h) begin
         if (cmd == LBP_CMD_FLUSH) return;
         if (cfg_color)
            sample = LBP_PIX_W'((int'(r_in) + int'(g_in) + int'(b_in)) / 3);
         else
            sample = r_in;
      end
      col = (in_col < LBP_MAX_WIDTH) ? in_col : 0;
      above  = upper_row_mem[col];
      beside = middle_row_mem[col];
      upper_row_mem[col]  = beside;
      middle_row_mem[col] = sample;
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = above;
      win[1][2] = beside;
      win[2][2] = sample;

      emit = (in_row > 1) || (in_row == 1 && in_col >= 1);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
      if (!emit) return;

      center = win[1][1];
      code = '0;
      for (int r = 0; r < 3; r++) begin
         nr = out_row + r - 1;
         if (nr >= 0 && nr < h) begin
            for (int c = 0; c < 3; c++) begin
               nc = out_col + c - 1;
               if (nc >= 0 && nc < w && win[r][c] >= center)
                  code = code | NEIGHBOR_WEIGHT[r][c];
            end
         end
      end
      last = (out_row + 1 >= h) && (out_col + 1 >= w);
      item.code = code;
      item.last = last;
      expected_codes.push_back(item);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      if (last) restart_frame();
   endfunction

   always @(posedge clock) begin : watch
      lbp_result_type want;
      logic bad;
      if (reset) begin
         cfg_width  = LBP_WIDTH_RESET;
         cfg_height = LBP_HEIGHT_RESET;
         cfg_color  = 1'b0;
         restart_frame();
         expected_codes.delete();
      end else begin
         // A result leaves only after its item has passed the input stage and the
         // result register, so the output side is handled before this edge's input item.
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected code, expected none, actual code %0d last %0b",
                        $time, rsp_lbp_code, rsp_frame_last);
            end else begin
               want = expected_codes.pop_front();
               bad = 1'b0;
               if (rsp_lbp_code !== want.code) begin
                  bad = 1'b1;
                  $display("%0t: lbp_code mismatch, expected %0d actual %0d",
                           $time, want.code, rsp_lbp_code);
               end
               if (rsp_frame_last !== want.last) begin
                  bad = 1'b1;
                  $display("%0t: frame_last mismatch, expected %0b actual %0b",
                           $time, want.last, rsp_frame_last);
               end
               if (bad) mismatch_count++;
            end
         end
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         if (req_valid && req_ready) shift_in_pixel(req_cmd, req_red, req_green, req_blue);
      end
      errors  <= mismatch_count;
      pending <= expected_codes.size();
   end

endmodule

@@ verif/tb.sv @@
// tb: top of the lbp_3x3_stream testbench. Makes the clock, reset, items and
// register writes, and gives the verdict. Depends on lbp_pkg, lbp_tb_pkg and lbp_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lbp_pkg::*;
   import lbp_tb_pkg::*;

   // Counted items for the whole run; ignored flush items are not counted.
   // The random frames take what the two large frames at the end leave.
   localparam int ITEM_TARGET = 1600;
   // Pixels sent of the clamped-width frame; enough to wrap past the line
   // length and bring out codes of its first row.
   localparam int CLAMP_PIXELS = 1100;
   // Pixels sent of the tallest frame before it is cut short.
   localparam int TALL_PIXELS = 200;
   // Cycles without any accepted item on any channel before the run is
   // declared hung. The slowest legal wait is a settle pause or a short
   // run of receiver stalls, both far below this.
   localparam int WATCHDOG_LIMIT = 4000;
   // Cycles allowed after the last result for an item still in flight
   // that produces no code; the block has two register stages.
   localparam int SETTLE_CYCLES = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_cmd   = LBP_CMD_PIXEL;
   logic [LBP_PIX_W-1:0]      req_red   = '0;
   logic [LBP_PIX_W-1:0]      req_green = '0;
   logic [LBP_PIX_W-1:0]      req_blue  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [LBP_PIX_W-1:0]      rsp_lbp_code;
   logic                      rsp_frame_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [LBP_CSR_IDX_W-1:0]  csr_index = LBP_CSR_WIDTH;
   logic [LBP_CSR_DATA_W-1:0] csr_data  = '0;

   int errors;
   int pending;

   // Random idling on both channels is on unless this is low.
   logic gaps_on = 1'b1;
   int   item_count = 0;
   int   stall_cycles = 0;

   // Effective frame size as the block sees it after the last configuration.
   int frame_w = 640;
   int frame_h = 480;

   always #5ns clock = ~clock;

   lbp_3x3_stream DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_lbp_code   (rsp_lbp_code),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   lbp_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_lbp_code   (rsp_lbp_code),
      .rsp_frame_last (rsp_frame_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .errors         (errors),
      .pending        (pending)
   );

   // The receiver stalls at random about 27 percent of the time while gaps are on.
   always @(negedge clock) begin
      if (gaps_on)
         rsp_ready <= ($urandom_range(99) >= 27);
      else
         rsp_ready <= 1'b1;
   end

   // Any accepted item on any channel shows the block is alive.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("tb failed");
            $finish;
         end
      end
   end

   // Presents one item at a falling edge and holds it until it is accepted.
   // Valid stays high afterwards; the next call lowers it only for a gap.
   task automatic send_item(input lbp_cmd_type cmd, input logic [LBP_PIX_W-1:0] r,
                            input logic [LBP_PIX_W-1:0] g, input logic [LBP_PIX_W-1:0] b);
      @(negedge clock);
      while (gaps_on && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops the input side, waits for every predicted code to come out, and
   // then lets the pipeline empty of items that give no code.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [LBP_CSR_IDX_W-1:0] idx,
                                 input logic [LBP_CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Writes all three registers, with junk in the unused width and color data bits,
   // which the block must drop, and records the frame size it will actually use.
   task automatic configure(input int w, input int h, input logic color);
      settle();
      write_register(LBP_CSR_WIDTH, {2'($urandom_range(3)), LBP_WID_W'(w)});
      write_register(LBP_CSR_HEIGHT, LBP_HGT_W'(h));
      write_register(LBP_CSR_COLOR, {12'($urandom), color});
      frame_w = (w == 0) ? 1 : (w > LBP_MAX_WIDTH) ? LBP_MAX_WIDTH : w;
      frame_h = (h == 0) ? 1 : h;
   endtask

   // Style 0 is full-range noise, style 1 a narrow range full of ties, and
   // style 2 only the two extremes.
   function automatic logic [LBP_PIX_W-1:0] pick_sample(input int style);
      case (style)
         1:       return LBP_PIX_W'($urandom_range(3));
         2:       return ($urandom_range(1) != 0) ? '1 : '0;
         default: return LBP_PIX_W'($urandom);
      endcase
   endfunction

   // One frame of the current size. Flush items are sprinkled between the
   // pixels, where the block must ignore them. After the last pixel, width
   // plus one drain items bring out the remaining codes; about half of them
   // are pixel items, which must act as flushes. A frame aborted before its
   // abort_at pixel leaves the block mid-frame for the next configuration.
   task automatic send_frame(input int style, input int abort_at);
      for (int i = 0; i < frame_w * frame_h; i++) begin
         if (i == abort_at) return;
         if ($urandom_range(19) == 0)
            send_item(LBP_CMD_FLUSH, pick_sample(0), pick_sample(0), pick_sample(0));
         send_item(LBP_CMD_PIXEL, pick_sample(style), pick_sample(style), pick_sample(style));
         item_count++;
      end
      for (int i = 0; i <= frame_w; i++) begin
         send_item(($urandom_range(1) != 0) ? LBP_CMD_FLUSH : LBP_CMD_PIXEL,
                   pick_sample(0), pick_sample(0), pick_sample(0));
         item_count++;
      end
   endtask

   initial begin : stimulus
      int  w, h, pick, style, abort_at;
      logic color;
      logic need_config;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset configuration is 640 by 480 in gray. A flush at the start of a
      // frame gives nothing; two pixels then leave the frame half begun, and
      // the configuration below must restart it.
      send_item(LBP_CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
      send_item(LBP_CMD_PIXEL, 8'h80, 8'h00, 8'h00);
      send_item(LBP_CMD_PIXEL, 8'h7F, 8'hFF, 8'hFF);

      // A 3 by 3 gray frame with both extremes and ties against the center.
      configure(3, 3, 1'b0);
      send_item(LBP_CMD_PIXEL, 8'd255, 8'd0, 8'd0);
      send_item(LBP_CMD_PIXEL, 8'd0, 8'd255, 8'd255);
      send_item(LBP_CMD_PIXEL, 8'd255, 8'd0, 8'd0);
      // Mid-frame flush is ignored, and a write to the spare index must not
      // restart the frame.
      send_item(LBP_CMD_FLUSH, 8'd0, 8'd0, 8'd0);
      settle();
      write_register(LBP_CSR_SPARE, '1);
      send_item(LBP_CMD_PIXEL, 8'd0, 8'd0, 8'd0);
      send_item(LBP_CMD_PIXEL, 8'd128, 8'd0, 8'd0);
      send_item(LBP_CMD_PIXEL, 8'd0, 8'd0, 8'd0);
      send_item(LBP_CMD_PIXEL, 8'd128, 8'd0, 8'd0);
      send_item(LBP_CMD_PIXEL, 8'd128, 8'd0, 8'd0);
      send_item(LBP_CMD_PIXEL, 8'd255, 8'd0, 8'd0);
      send_item(LBP_CMD_FLUSH, 8'd0, 8'd0, 8'd0);
      send_item(LBP_CMD_PIXEL, 8'd255, 8'd255, 8'd255);
      send_item(LBP_CMD_FLUSH, 8'd0, 8'd0, 8'd0);
      send_item(LBP_CMD_PIXEL, 8'd0, 8'd0, 8'd0);

      // Zero width and zero height act as one; color mode at full scale.
      configure(0, 0, 1'b1);
      send_item(LBP_CMD_FLUSH, 8'd0, 8'd0, 8'd0);
      send_item(LBP_CMD_PIXEL, 8'd255, 8'd255, 8'd255);
      send_item(LBP_CMD_FLUSH, 8'd0, 8'd0, 8'd0);
      send_item(LBP_CMD_FLUSH, 8'd0, 8'd0, 8'd0);

      // Single-row color frame; the first drain item gives no code.
      configure(2, 1, 1'b1);
      send_item(LBP_CMD_PIXEL, 8'd255, 8'd255, 8'd254);
      send_item(LBP_CMD_PIXEL, 8'd1, 8'd1, 8'd0);
      send_item(LBP_CMD_FLUSH, 8'd0, 8'd0, 8'd0);
      send_item(LBP_CMD_FLUSH, 8'd0, 8'd0, 8'd0);
      send_item(LBP_CMD_PIXEL, 8'd9, 8'd9, 8'd9);

      // Random frames, mostly small, some reusing the previous configuration
      // back to back, a few cut short.
      need_config = 1'b1;
      while (item_count < ITEM_TARGET - CLAMP_PIXELS - TALL_PIXELS) begin
         pick = $urandom_range(99);
         if (pick < 5)       w = 0;
         else if (pick < 72) w = $urandom_range(1, 12);
         else if (pick < 92) w = $urandom_range(13, 64);
         else                w = $urandom_range(65, 160);
         pick = $urandom_range(99);
         if (pick < 5)                 h = 0;
         else if (w > 64 || pick < 75) h = $urandom_range(1, 4);
         else                          h = $urandom_range(5, 16);
         color = 1'($urandom_range(1));
         style = $urandom_range(2);
         if (need_config || $urandom_range(2) != 0) configure(w, h, color);
         abort_at = ($urandom_range(11) == 0) ?
                    int'($urandom_range(frame_w * frame_h - 1)) : -1;
         send_frame(style, abort_at);
         need_config = (abort_at >= 0);
      end

      // The largest sizes: a width beyond the limit that clamps to the
      // line length, run as a long stretch with no idling on either side,
      // and the tallest height the register holds. Both are cut short.
      gaps_on <= 1'b0;
      configure(2047, 2, 1'b0);
      send_frame(0, CLAMP_PIXELS);
      gaps_on <= 1'b1;
      configure(1, 8191, 1'b1);
      send_frame(1, TALL_PIXELS);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (errors == 0 && pending == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
